### rtl/adu_pkg.sv
// ----------------------------------------------------------------------------
// adu_pkg
// Shared widths, fixed-point constants, mode codes and stage payload types
// for the activation and derivative unit.
// ----------------------------------------------------------------------------
package adu_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    // sigmoid value and derivative span [0, 1.0]: one integer bit
    localparam int Y_W    = FRAC_BITS + 1;
    localparam int PROD_W = 2 * Y_W;

    localparam logic [Y_W-1:0] ONE_FX = Y_W'(1 << FRAC_BITS);

    // PLAN breakpoints on |x|
    localparam logic [DATA_WIDTH-1:0] SIG_TH_SAT = DATA_WIDTH'(5 * (1 << FRAC_BITS));
    localparam logic [DATA_WIDTH-1:0] SIG_TH_MID = DATA_WIDTH'((19 * (1 << FRAC_BITS)) / 8);
    localparam logic [DATA_WIDTH-1:0] SIG_TH_LOW = DATA_WIDTH'(1 << FRAC_BITS);

    // PLAN offsets
    localparam logic [DATA_WIDTH-1:0] SIG_OFS_MID = DATA_WIDTH'((27 * (1 << FRAC_BITS)) / 32);
    localparam logic [DATA_WIDTH-1:0] SIG_OFS_LOW = DATA_WIDTH'((5 * (1 << FRAC_BITS)) / 8);
    localparam logic [DATA_WIDTH-1:0] SIG_OFS_CTR = DATA_WIDTH'((1 << FRAC_BITS) / 2);

    typedef enum logic [1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_SIGMOID = 2'd1,
        MODE_RELU    = 2'd2
    } mode_t;

    // payload handed from the sigmoid stages to the derivative stages
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] act;
        logic [Y_W-1:0]               sig_y;
        logic [Y_W-1:0]               deriv_const;
        logic                         use_prod;
    } plan_data_t;

endpackage

### rtl/adu_if.sv
// ----------------------------------------------------------------------------
// adu channel interfaces
// Valid/ready channels for weighted-sum requests and activation results.
// ----------------------------------------------------------------------------
interface adu_sum_if
    import adu_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sum_in;

    modport source (output valid, output sum_in, input ready);
    modport sink   (input valid, input sum_in, output ready);
endinterface

interface adu_result_if
    import adu_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] act_out;
    logic [Y_W-1:0]               deriv_out;

    modport source (output valid, output act_out, output deriv_out, input ready);
    modport sink   (input valid, input act_out, input deriv_out, output ready);
endinterface

### rtl/adu_plan.sv
// ----------------------------------------------------------------------------
// adu_plan
// Two pipeline stages: input capture with |x|, then PLAN sigmoid evaluation
// and linear/relu selection.
// ----------------------------------------------------------------------------
module adu_plan
    import adu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mode_t       mode,
    adu_sum_if.sink     sum_ch,
    output logic        out_valid,
    input  logic        out_ready,
    output plan_data_t  out_data
);

    // stage A
    logic                         a_valid_reg;
    logic signed [DATA_WIDTH-1:0] a_x_reg;
    logic [DATA_WIDTH-1:0]        a_abs_reg;
    logic                         a_neg_reg;
    mode_t                        a_mode_reg;
    logic                         a_ready;
    logic [DATA_WIDTH-1:0]        a_abs_next;

    // stage B
    logic       b_valid_reg;
    plan_data_t b_data_reg;
    plan_data_t b_data_next;
    logic       b_ready;

    logic [DATA_WIDTH-1:0] y_mag;
    logic [Y_W-1:0]        y_pos;
    logic [Y_W-1:0]        y_val;
    logic                  x_pos;

    assign b_ready      = !b_valid_reg || out_ready;
    assign a_ready      = !a_valid_reg || b_ready;
    assign sum_ch.ready = a_ready;

    // two's complement magnitude; the most negative value maps to 2^(W-1)
    assign a_abs_next = sum_ch.sum_in[DATA_WIDTH-1] ? (~sum_ch.sum_in + 1'b1)
                                                    : sum_ch.sum_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= sum_ch.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && sum_ch.valid)
        begin
            a_x_reg    <= sum_ch.sum_in;
            a_abs_reg  <= a_abs_next;
            a_neg_reg  <= sum_ch.sum_in[DATA_WIDTH-1];
            a_mode_reg <= mode;
        end
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    // PLAN segments, all below 1.0 except saturation
    always_comb
    begin
        if (a_abs_reg >= SIG_TH_SAT)
        begin
            y_mag = DATA_WIDTH'(ONE_FX);
        end
        else if (a_abs_reg >= SIG_TH_MID)
        begin
            y_mag = (a_abs_reg >> 5) + SIG_OFS_MID;
        end
        else if (a_abs_reg >= SIG_TH_LOW)
        begin
            y_mag = (a_abs_reg >> 3) + SIG_OFS_LOW;
        end
        else
        begin
            y_mag = (a_abs_reg >> 2) + SIG_OFS_CTR;
        end
    end

    assign y_pos = y_mag[Y_W-1:0];
    assign y_val = a_neg_reg ? (ONE_FX - y_pos) : y_pos;
    assign x_pos = !a_neg_reg && (a_x_reg != '0);

    always_comb
    begin
        b_data_next.sig_y = y_val;
        case (a_mode_reg)
            MODE_LINEAR:
            begin
                b_data_next.act         = a_x_reg;
                b_data_next.deriv_const = ONE_FX;
                b_data_next.use_prod    = 1'b0;
            end
            MODE_SIGMOID:
            begin
                b_data_next.act         = DATA_WIDTH'(y_val);
                b_data_next.deriv_const = '0;
                b_data_next.use_prod    = 1'b1;
            end
            MODE_RELU:
            begin
                b_data_next.act         = x_pos ? a_x_reg : '0;
                b_data_next.deriv_const = x_pos ? ONE_FX : '0;
                b_data_next.use_prod    = 1'b0;
            end
            default:
            begin
                b_data_next.act         = '0;
                b_data_next.deriv_const = '0;
                b_data_next.use_prod    = 1'b0;
            end
        endcase
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

### rtl/adu_deriv.sv
// ----------------------------------------------------------------------------
// adu_deriv
// Two pipeline stages: sigmoid derivative product s*(1-s), then truncation,
// derivative selection and the output register.
// ----------------------------------------------------------------------------
module adu_deriv
    import adu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  plan_data_t    in_data,
    adu_result_if.source  res_ch
);

    // stage C
    logic                         c_valid_reg;
    logic [PROD_W-1:0]            c_prod_reg;
    logic [PROD_W-1:0]            c_prod_next;
    logic signed [DATA_WIDTH-1:0] c_act_reg;
    logic [Y_W-1:0]               c_dconst_reg;
    logic                         c_use_prod_reg;
    logic                         c_ready;

    // stage D (output)
    logic                         d_valid_reg;
    logic signed [DATA_WIDTH-1:0] d_act_reg;
    logic [Y_W-1:0]               d_deriv_reg;
    logic [Y_W-1:0]               d_deriv_next;
    logic                         d_ready;

    assign d_ready  = !d_valid_reg || res_ch.ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    assign c_prod_next  = PROD_W'(in_data.sig_y) * PROD_W'(ONE_FX - in_data.sig_y);
    // s*(1-s) <= 0.25, so the truncated product fits the derivative width
    assign d_deriv_next = c_use_prod_reg ? c_prod_reg[FRAC_BITS +: Y_W] : c_dconst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_prod_reg     <= c_prod_next;
            c_act_reg      <= in_data.act;
            c_dconst_reg   <= in_data.deriv_const;
            c_use_prod_reg <= in_data.use_prod;
        end
        if (d_ready && c_valid_reg)
        begin
            d_act_reg   <= c_act_reg;
            d_deriv_reg <= d_deriv_next;
        end
    end

    assign res_ch.valid     = d_valid_reg;
    assign res_ch.act_out   = d_act_reg;
    assign res_ch.deriv_out = d_deriv_reg;

endmodule

### rtl/activation_and_derivative_unit_top.sv
// ----------------------------------------------------------------------------
// activation_and_derivative_unit_top
// Linear / PLAN sigmoid / relu activation with derivative, Q4.12 fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  sum_ch    in   valid/ready    sum_in    (s16 Q4.12)
//  res_ch    out  valid/ready    act_out   (s16 Q4.12), deriv_out (u13 Q1.12)
//  cfg       in   cfg_we         cfg_wdata (mode, 2 bits)
//
//  Four register stages: |x| capture, PLAN segment select, derivative
//  multiply, output register. One request per cycle while res_ch is not stalled.
//  Each stage holds its own valid bit and loads whenever it is empty or the
//  next stage moves, so a stalled output still lets earlier stages fill.
//  Reset clears all valid bits and sets mode to linear.
// ----------------------------------------------------------------------------
module activation_and_derivative_unit_top
    import adu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_wdata,
    adu_sum_if.sink       sum_ch,
    adu_result_if.source  res_ch
);

    mode_t      mode_reg;
    logic       plan_valid;
    logic       plan_ready;
    plan_data_t plan_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LINEAR;
        end
        else if (cfg_we)
        begin
            mode_reg <= mode_t'(cfg_wdata);
        end
    end

    adu_plan u_plan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .sum_ch    (sum_ch),
        .out_valid (plan_valid),
        .out_ready (plan_ready),
        .out_data  (plan_data)
    );

    adu_deriv u_deriv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (plan_valid),
        .in_ready (plan_ready),
        .in_data  (plan_data),
        .res_ch   (res_ch)
    );

endmodule
